### src/assert_macros.svh
// Assertion macros for the module that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define FCRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property on every rising edge of clk, reset included.
`define FCRB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/fcrb_pkg.sv
// Package with the types, codes and constants of the fuse controller register block.
package fcrb_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned REG_COUNT = 10;

  localparam logic [7:0] OP_READ = 8'd6;
  localparam logic [7:0] OP_WRITE = 8'd7;
  localparam logic [2:0] BAR_CTRL = 3'd4;
  localparam logic [2:0] BAR_FUSE = 3'd1;
  localparam logic [7:0] SIZE_WORD = 8'd4;
  localparam logic [15:0] FUSE_TOP = 16'h07FF;

  localparam logic [31:0] CMD_A = 32'h0002_0000;
  localparam logic [31:0] CMD_B = 32'h0004_0000;
  localparam logic [31:0] CMD_DONE = 32'h0000_0090;
  localparam logic [31:0] DBG_CLEAR = 32'h8000_0000;
  localparam logic [31:0] FSM_START = 32'h0080_0000;
  localparam logic [31:0] FSM_STOP = 32'h0100_0000;
  localparam logic [31:0] SENSE_FLAG = 32'h0000_0002;

  localparam logic [15:0] OFF_CONTROL = 16'h0000;
  localparam logic [15:0] OFF_GLOBAL = 16'h0004;
  localparam logic [15:0] OFF_KEY = 16'h0008;
  localparam logic [15:0] OFF_FUSE_ADDR = 16'h000C;
  localparam logic [15:0] OFF_XFER_SIZE = 16'h0010;
  localparam logic [15:0] OFF_SEQ_CTRL = 16'h0014;
  localparam logic [15:0] OFF_HOLD = 16'h001C;
  localparam logic [15:0] OFF_DEBUG = 16'h0080;
  localparam logic [15:0] OFF_AUX_A = 16'h1020;
  localparam logic [15:0] OFF_AUX_B = 16'h1024;

  typedef enum logic [3:0] {
    REG_CONTROL   = 4'd0,
    REG_GLOBAL    = 4'd1,
    REG_KEY       = 4'd2,
    REG_FUSE_ADDR = 4'd3,
    REG_XFER_SIZE = 4'd4,
    REG_SEQ_CTRL  = 4'd5,
    REG_HOLD      = 4'd6,
    REG_DEBUG     = 4'd7,
    REG_AUX_A     = 4'd8,
    REG_AUX_B     = 4'd9
  } reg_sel_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  opcode;
    logic [2:0]  bar;
    logic [15:0] offset;
    logic [7:0]  access_size;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic     ok;
    logic     wr;
    reg_sel_t sel;
  } dec_t;

endpackage

### src/fcrb_if.sv
// Interfaces of the request, response and configuration channels.
interface fcrb_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  opcode;
  logic [2:0]  bar;
  logic [15:0] offset;
  logic [7:0]  access_size;
  logic [31:0] write_data;

  modport source (output valid, action, opcode, bar, offset, access_size, write_data,
                  input ready);
  modport sink (input valid, action, opcode, bar, offset, access_size, write_data,
                output ready);
endinterface

interface fcrb_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        access_error;
  logic [7:0]  response_attribute;

  modport source (output valid, read_data, access_error, response_attribute,
                  input ready);
  modport sink (input valid, read_data, access_error, response_attribute,
                output ready);
endinterface

interface fcrb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### src/fcrb_decode.sv
// Access decoder that checks a request and selects its target register.
module fcrb_decode (
  input  fcrb_pkg::req_t req,
  output fcrb_pkg::dec_t dec
);
  import fcrb_pkg::*;

  logic     hit;
  reg_sel_t sel;
  logic     fuse_ok;

  always_comb begin
    hit = 1'b1;
    sel = REG_CONTROL;
    case (req.offset)
      OFF_CONTROL:   sel = REG_CONTROL;
      OFF_GLOBAL:    sel = REG_GLOBAL;
      OFF_KEY:       sel = REG_KEY;
      OFF_FUSE_ADDR: sel = REG_FUSE_ADDR;
      OFF_XFER_SIZE: sel = REG_XFER_SIZE;
      OFF_SEQ_CTRL:  sel = REG_SEQ_CTRL;
      OFF_HOLD:      sel = REG_HOLD;
      OFF_DEBUG:     sel = REG_DEBUG;
      OFF_AUX_A:     sel = REG_AUX_A;
      OFF_AUX_B:     sel = REG_AUX_B;
      default:       hit = 1'b0;
    endcase
  end

  assign fuse_ok = (req.offset <= FUSE_TOP) && (req.offset[1:0] == 2'b00);

  always_comb begin
    dec.ok = 1'b0;
    dec.wr = 1'b0;
    dec.sel = sel;
    if (req.access_size == SIZE_WORD) begin
      if (!req.action) begin
        if (req.opcode == OP_READ) begin
          if (req.bar == BAR_CTRL) begin
            dec.ok = hit;
          end else if (req.bar == BAR_FUSE) begin
            dec.ok = fuse_ok;
            dec.sel = REG_AUX_B;
          end
        end
      end else if (req.opcode == OP_WRITE && req.bar == BAR_CTRL) begin
        dec.ok = hit;
        dec.wr = hit;
      end
    end
  end

endmodule

### src/fcrb_regs.sv
// Register file with the write path, command self-clear and read select.
module fcrb_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  fcrb_pkg::reg_sel_t sel,
  input  logic [31:0]       wdata,
  output logic [31:0]       rdata
);
  import fcrb_pkg::*;

  logic [DATA_W-1:0] regs [REG_COUNT];
  logic [DATA_W-1:0] regs_next [REG_COUNT];
  logic [DATA_W-1:0] wr_vals [REG_COUNT];
  logic [DATA_W-1:0] cw_a;
  logic [DATA_W-1:0] ds_a;

  always_comb begin
    wr_vals = regs;
    wr_vals[sel] = wdata;
    regs_next = regs;
    if (wr_en) begin
      regs_next = wr_vals;
      cw_a = wr_vals[REG_CONTROL];
      if ((cw_a & CMD_A) != '0) begin
        cw_a = (cw_a & ~(CMD_A | CMD_DONE)) | CMD_DONE;
      end
      if ((cw_a & CMD_B) != '0) begin
        cw_a = CMD_DONE;
      end
      regs_next[REG_CONTROL] = cw_a;
      ds_a = wr_vals[REG_DEBUG];
      if ((ds_a & DBG_CLEAR) != '0) begin
        ds_a = '0;
      end
      if ((wr_vals[REG_SEQ_CTRL] & FSM_START) != '0) begin
        ds_a = ds_a | SENSE_FLAG;
      end
      regs_next[REG_DEBUG] = ds_a;
      regs_next[REG_SEQ_CTRL] = wr_vals[REG_SEQ_CTRL] & ~(FSM_START | FSM_STOP);
    end else begin
      cw_a = regs[REG_CONTROL];
      ds_a = regs[REG_DEBUG];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs[i] <= '0;
      end
    end else begin
      regs <= regs_next;
    end
  end

  assign rdata = regs[sel];

endmodule

### src/fuse_controller_register_block.sv
// Top level of the fuse controller register block.
//
// Requests arrive on req: a read or a write with opcode, bar, offset, size
// and write data. Each request yields exactly one response on rsp with the
// read data, an error flag and the security attribute. The attribute is
// written through cfg, which is always ready, and should change only while
// no request is in flight.
// A request is captured in an input register and decoded from there; when it
// advances, the register file is read or updated and the response register is
// loaded. A response the receiver has not taken holds it in the input register.
// One request is accepted every cycle while responses are taken; the
// input register takes a new request whenever the one it holds advances
// to the response register.
// Reset clears all registers, the attribute and both pipeline stages.
// When the receiver stalls, the response and any request behind it hold,
// and req.ready falls while a request waits behind an untaken response.
module fuse_controller_register_block (
  input  logic clk,
  input  logic rst,
  fcrb_req_if.sink   req,
  fcrb_rsp_if.source rsp,
  fcrb_cfg_if.sink   cfg
);
  import fcrb_pkg::*;
  `include "assert_macros.svh"

  logic              s1_valid;
  req_t              s1_req;
  dec_t              dec;
  logic              advance;
  logic [ATTR_W-1:0] attr;
  logic [DATA_W-1:0] rdata;
  logic              o_valid;
  logic [DATA_W-1:0] o_data;
  logic              o_error;
  logic [ATTR_W-1:0] o_attr;

  assign advance = s1_valid && (!o_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= '0;
    end else if (cfg.valid) begin
      attr <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req <= '{action: req.action, opcode: req.opcode, bar: req.bar,
                  offset: req.offset, access_size: req.access_size,
                  write_data: req.write_data};
    end
  end

  fcrb_decode u_decode (
    .req (s1_req),
    .dec (dec)
  );

  fcrb_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .wr_en (advance && dec.wr),
    .sel   (dec.sel),
    .wdata (s1_req.write_data),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_data <= (dec.ok && !dec.wr) ? rdata : '0;
      o_error <= !dec.ok;
      o_attr <= dec.ok ? attr : '0;
    end
  end

  assign rsp.valid = o_valid;
  assign rsp.read_data = o_data;
  assign rsp.access_error = o_error;
  assign rsp.response_attribute = o_attr;

  `FCRB_ASSERT(a_accept_fills, (req.valid && req.ready) |=> s1_valid, "accepted request lost")
  `FCRB_ASSERT(a_stage_holds, (s1_valid && !advance) |=> (s1_valid && $stable(s1_req)),
               "stalled request changed")
  `FCRB_ASSERT(a_advance_loads, advance |=> o_valid, "response not loaded")
  `FCRB_ASSERT(a_error_clean, (o_valid && o_error) |-> (o_attr == '0 && o_data == '0),
               "error response carries data")

endmodule
